>>> hw/rtl/sctsu_pkg.sv
// sctsu_pkg: shared types and constants for the sorted code table search unit
// item structs, command and status codes, code range check
// no dependencies
package sctsu_pkg;

  localparam int CODE_W  = 32;
  localparam int STORE_W = 21;
  localparam int INDEX_W = 11;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_NOT_FOUND  = 3'd1,
    STAT_NOT_LOADED = 3'd2,
    STAT_INVALID    = 3'd3,
    STAT_UNSORTED   = 3'd4,
    STAT_FULL       = 3'd5,
    STAT_BLOCKED    = 3'd6,
    STAT_SPARE      = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEARCH,
    ST_RESULT
  } state_t;

  typedef struct packed {
    cmd_t              command;
    logic [1:0]        table_select;
    logic [CODE_W-1:0] code;
    logic              last_entry;
  } req_item_t;

  typedef struct packed {
    status_t            status;
    logic [INDEX_W-1:0] entry_index;
  } rsp_item_t;

  localparam logic [CODE_W-1:0] CODE_MIN       = 32'h0000_0020;
  localparam logic [CODE_W-1:0] CTRL_LO        = 32'h0000_007F;
  localparam logic [CODE_W-1:0] CTRL_END       = 32'h0000_00A0;
  localparam logic [CODE_W-1:0] SURROGATE_LO   = 32'h0000_D800;
  localparam logic [CODE_W-1:0] SURROGATE_HI   = 32'h0000_DFFF;
  localparam logic [CODE_W-1:0] CODE_MAX       = 32'h0010_FFFF;

  // printable, non-surrogate, inside the unicode range
  function automatic logic code_valid(input logic [CODE_W-1:0] c);
    logic bad;
    bad = (c < CODE_MIN) || ((c >= CTRL_LO) && (c < CTRL_END)) ||
          ((c >= SURROGATE_LO) && (c <= SURROGATE_HI)) || (c > CODE_MAX);
    return !bad;
  endfunction

endpackage

>>> hw/rtl/sorted_code_table_search_unit.sv
// sorted_code_table_search_unit: per-table code store with load checks and binary search
// uses sctsu_pkg for item types, codes and the code range check
// code store is one synchronous single-port-read memory, per-table status in flops
//
// sequence: clear, load and no-op items pass from acceptance through exec and result to the output register
// lookup: adds one memory read per search step in the search state, at most clog2(count+1)
//   steps; the search loop through the store read port sets the lookup time
// item flow: one item at a time, the next one taken the cycle after the result goes
//   out; a held result stalls input
// reset: counts, loaded and failed marks and previous codes clear at once; store
//   contents stay undefined and are only read below the entry count
module sorted_code_table_search_unit
  import sctsu_pkg::*;
#(
  parameter int MAX_ENTRIES = 2048,
  parameter int TABLES      = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  // index, count and table widths
  localparam int IW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int TW    = (TABLES > 1) ? $clog2(TABLES) : 1;
  localparam int DEPTH = TABLES * (2 ** IW);

  // fsm and latched item
  state_t    state, state_next;
  req_item_t item;

  // search window [lo, hi) and the probe address in flight
  logic [CW-1:0] lo, lo_next;
  logic [CW-1:0] hi, hi_next;
  logic [IW-1:0] mid, mid_next;

  rsp_item_t result, result_next;

  // per-table state
  logic [CW-1:0]      entry_count   [TABLES];
  logic               table_loaded  [TABLES];
  logic               load_failed   [TABLES];
  logic [STORE_W-1:0] previous_code [TABLES];

  // code store
  logic [STORE_W-1:0] code_store [DEPTH];
  logic [STORE_W-1:0] rd_data;
  logic               rd_en;
  logic [TW+IW-1:0]   rd_addr;
  logic               mem_we;
  logic [TW+IW-1:0]   wr_addr;

  // table update from the exec step
  logic               tbl_we;
  logic [CW-1:0]      new_count;
  logic               new_loaded;
  logic               new_failed;
  logic [STORE_W-1:0] new_prev;

  logic          tbl_ok;
  logic [TW-1:0] t_idx;
  logic [CW-1:0] cur_count;
  logic          cur_loaded;
  logic          cur_failed;
  logic [STORE_W-1:0] cur_prev;

  // search step values
  logic [CODE_W-1:0] probe_code;
  logic [CW-1:0]     s_lo, s_hi, s_mid;

  assign tbl_ok     = (32'(item.table_select) < TABLES);
  assign t_idx      = TW'(item.table_select);
  assign cur_count  = entry_count[t_idx];
  assign cur_loaded = table_loaded[t_idx];
  assign cur_failed = load_failed[t_idx];
  assign cur_prev   = previous_code[t_idx];
  assign probe_code = {{(CODE_W - STORE_W){1'b0}}, rd_data};

  assign req_ready  = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    lo_next     = lo;
    hi_next     = hi;
    mid_next    = mid;
    result_next = result;
    rd_en       = 1'b0;
    rd_addr     = {t_idx, mid};
    mem_we      = 1'b0;
    wr_addr     = {t_idx, cur_count[IW-1:0]};
    tbl_we      = 1'b0;
    new_count   = cur_count;
    new_loaded  = cur_loaded;
    new_failed  = cur_failed;
    new_prev    = cur_prev;
    s_lo        = lo;
    s_hi        = hi;
    s_mid       = '0;

    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        result_next.status      = STAT_OK;
        result_next.entry_index = '0;
        state_next              = ST_RESULT;
        if (!tbl_ok) begin
          result_next.status = STAT_NOT_LOADED;
        end else begin
          unique case (item.command)
            CMD_CLEAR: begin
              tbl_we     = 1'b1;
              new_count  = '0;
              new_loaded = 1'b0;
              new_failed = 1'b0;
              new_prev   = '0;
            end
            CMD_LOAD: begin
              if (cur_failed || cur_loaded) begin
                result_next.status = STAT_BLOCKED;
              end else begin
                if (!code_valid(item.code)) begin
                  result_next.status = STAT_INVALID;
                end else if ((cur_count != '0) &&
                             ({{(CODE_W - STORE_W){1'b0}}, cur_prev} >= item.code)) begin
                  result_next.status = STAT_UNSORTED;
                end else if (cur_count == CW'(MAX_ENTRIES)) begin
                  result_next.status = STAT_FULL;
                end
                tbl_we = 1'b1;
                if (result_next.status != STAT_OK) begin
                  // any load error empties the table and locks it until cleared
                  new_count  = '0;
                  new_loaded = 1'b0;
                  new_failed = 1'b1;
                  new_prev   = '0;
                end else begin
                  mem_we     = 1'b1;
                  new_count  = cur_count + CW'(1);
                  new_loaded = item.last_entry;
                  new_prev   = item.code[STORE_W-1:0];
                end
              end
            end
            CMD_LOOKUP: begin
              if (!cur_loaded || (cur_count == '0)) begin
                result_next.status = STAT_NOT_LOADED;
              end else begin
                // first probe at the middle of [0, count)
                lo_next    = '0;
                hi_next    = cur_count;
                s_mid      = cur_count >> 1;
                mid_next   = s_mid[IW-1:0];
                rd_en      = 1'b1;
                rd_addr    = {t_idx, mid_next};
                state_next = ST_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SEARCH: begin
        // rd_data holds the entry at mid
        if (probe_code == item.code) begin
          result_next.status      = STAT_OK;
          result_next.entry_index = INDEX_W'(mid);
          state_next              = ST_RESULT;
        end else begin
          if (probe_code < item.code) begin
            s_lo = CW'(mid) + CW'(1);
          end else begin
            s_hi = CW'(mid);
          end
          lo_next = s_lo;
          hi_next = s_hi;
          if (s_lo < s_hi) begin
            // next probe issued in the same cycle as the compare
            s_mid    = s_lo + ((s_hi - s_lo) >> 1);
            mid_next = s_mid[IW-1:0];
            rd_en    = 1'b1;
            rd_addr  = {t_idx, mid_next};
          end else begin
            result_next.status      = STAT_NOT_FOUND;
            result_next.entry_index = '0;
            state_next              = ST_RESULT;
          end
        end
      end

      ST_RESULT: begin
        // hand over once the output register is free or being drained
        if (!rsp_valid || rsp_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // fsm and search registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) begin
      item <= req;
    end
    lo     <= lo_next;
    hi     <= hi_next;
    mid    <= mid_next;
    result <= result_next;
  end

  // per-table status
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLES; i++) begin
        entry_count[i]   <= '0;
        table_loaded[i]  <= 1'b0;
        load_failed[i]   <= 1'b0;
        previous_code[i] <= '0;
      end
    end else if (tbl_we) begin
      entry_count[t_idx]   <= new_count;
      table_loaded[t_idx]  <= new_loaded;
      load_failed[t_idx]   <= new_failed;
      previous_code[t_idx] <= new_prev;
    end
  end

  // code store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      code_store[wr_addr] <= item.code[STORE_W-1:0];
    end
    if (rd_en) begin
      rd_data <= code_store[rd_addr];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_RESULT && (!rsp_valid || rsp_ready)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESULT && (!rsp_valid || rsp_ready)) begin
      rsp <= result;
    end
  end

  // checks

  // the probe address always lies inside the search window
  a_probe_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> ((CW'(mid) >= lo) && (CW'(mid) < hi)))
    else $error("search probe outside window");

  // a table never holds more entries than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && tbl_ok) |-> (cur_count <= CW'(MAX_ENTRIES)))
    else $error("entry count past capacity");

  // a failed table is never marked loaded
  a_failed_not_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && tbl_ok) |-> !(cur_failed && cur_loaded))
    else $error("table both failed and loaded");

  // an accepted item moves on to the exec state
  a_accept_after_result: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == ST_EXEC))
    else $error("accepted item not executed");

  // store is written only by a load whose checks passed
  a_write_on_ok: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> (result.status == STAT_OK && state == ST_RESULT))
    else $error("store written by a failing load");

endmodule
